// ===== sv/lzbd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzbd_pkg
// Types and constants shared by the LZ77 block decompressor modules.
// ----------------------------------------------------------------------------
package lzbd_pkg;

    localparam int unsigned WINDOW_SIZE = 4096;
    localparam int unsigned HIST_AW     = $clog2(WINDOW_SIZE);
    localparam int unsigned MAX_COPY    = 63;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSED_CODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_CODE        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_TABLE_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_TABLE_HIGH  = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_END     = 3'd1;
    localparam logic [2:0] ST_METHOD  = 3'd2;
    localparam logic [2:0] ST_FAR     = 3'd3;
    localparam logic [2:0] ST_SHORT   = 3'd4;

    typedef struct packed {
        logic [7:0]  in_byte;
        logic        last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        done_res;
        logic [23:0] total_length;
        logic [2:0]  status;
        logic        run_last;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  compressed_method_code;
        logic [7:0]  raw_method_code;
        logic [23:0] out_limit;
        logic [47:0] length_table_low;
        logic [47:0] length_table_high;
    } cfg_t;

    typedef struct packed {
        logic               wr_en;
        logic [HIST_AW-1:0] wr_addr;
        logic [7:0]         wr_data;
        logic               rd_en;
        logic [HIST_AW-1:0] rd_addr;
    } hist_req_t;

endpackage

// ===== sv/lz77_block_decompressor.sv =====
// ----------------------------------------------------------------------------
// lz77_block_decompressor
// LZSS block decompressor with configuration registers and output register.
// ----------------------------------------------------------------------------
// Takes one source byte per accepted input item and returns decoded bytes
// followed by one done item on the byte marked last. A literal or raw byte
// is first accepted and then emitted. A back-reference copies its bytes one
// at a time: each copied byte is read from the history memory through its
// registered read port, then emitted and written back to the history, so a
// copy holds the input until its last byte has gone out. The input is
// stalled until every result of the current item has been handed to the
// output register; a stalled output holds the sequencer.
module lz77_block_decompressor (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [lzbd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lzbd_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  lzbd_pkg::in_item_t                    in_item,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output lzbd_pkg::out_item_t                   out_item
);
    import lzbd_pkg::*;

    cfg_t       cfg_reg;
    logic       out_valid_reg;
    out_item_t  out_item_reg;
    logic       out_free;
    logic       emit;
    out_item_t  res;
    hist_req_t  hist_req;
    logic [7:0] hist_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.compressed_method_code <= 8'd0;
            cfg_reg.raw_method_code        <= 8'd1;
            cfg_reg.out_limit              <= 24'hFFFFFF;
            cfg_reg.length_table_low       <= 48'd0;
            cfg_reg.length_table_high      <= 48'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_COMPRESSED_CODE: cfg_reg.compressed_method_code <= cfg_data[7:0];
                CFG_RAW_CODE:        cfg_reg.raw_method_code        <= cfg_data[7:0];
                CFG_OUT_LIMIT:       cfg_reg.out_limit              <= cfg_data[23:0];
                CFG_LEN_TABLE_LOW:   cfg_reg.length_table_low       <= cfg_data;
                CFG_LEN_TABLE_HIGH:  cfg_reg.length_table_high      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    lzbd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .in_stall  (in_stall),
        .out_free  (out_free),
        .emit      (emit),
        .res       (res),
        .hist_req  (hist_req),
        .hist_data (hist_data)
    );

    lzbd_hist u_hist (
        .clk     (clk),
        .req     (hist_req),
        .rd_data (hist_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_item_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== sv/lzbd_hist.sv =====
// ----------------------------------------------------------------------------
// lzbd_hist
// History window memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lzbd_hist (
    input  logic                clk,
    input  lzbd_pkg::hist_req_t req,
    output logic [7:0]          rd_data
);
    import lzbd_pkg::*;

    logic [7:0] mem [WINDOW_SIZE];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// ===== sv/lzbd_core.sv =====
// ----------------------------------------------------------------------------
// lzbd_core
// Source byte decoder and byte-at-a-time copy sequencer.
// ----------------------------------------------------------------------------
module lzbd_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lzbd_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    input  lzbd_pkg::in_item_t   in_item,
    output logic                 in_stall,
    input  logic                 out_free,
    output logic                 emit,
    output lzbd_pkg::out_item_t  res,
    output lzbd_pkg::hist_req_t  hist_req,
    input  logic [7:0]           hist_data
);
    import lzbd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LIT  = 5'b00010,
        S_RD   = 5'b00100,
        S_WR   = 5'b01000,
        S_DONE = 5'b10000
    } seq_t;

    typedef enum logic [8:0] {
        PH_METHOD   = 9'b000000001,
        PH_FLAG     = 9'b000000010,
        PH_ITEM     = 9'b000000100,
        PH_CODE2    = 9'b000001000,
        PH_RAW_SKIP = 9'b000010000,
        PH_RAW_LO   = 9'b000100000,
        PH_RAW_HI   = 9'b001000000,
        PH_RAW_DATA = 9'b010000000,
        PH_STOP     = 9'b100000000
    } phase_t;

    seq_t        seq_reg, seq_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  flag_bits_reg, flag_bits_next;
    logic [3:0]  flags_left_reg, flags_left_next;
    logic [7:0]  held_reg, held_next;
    logic [15:0] raw_rem_reg, raw_rem_next;
    logic [2:0]  src_cnt_reg, src_cnt_next;
    logic [2:0]  end_status_reg, end_status_next;
    logic [23:0] produced_reg, produced_next;
    logic [7:0]  lit_reg, lit_next;
    logic [5:0]  copy_cnt_reg, copy_cnt_next;
    logic [11:0] dist_reg, dist_next;
    logic        done_pend_reg, done_pend_next;
    logic [2:0]  done_status_reg, done_status_next;
    logic        done_short_reg, done_short_next;

    logic        accept;
    logic [7:0]  b;
    logic        last;
    logic        room_ok;
    logic [11:0] dist_w;
    logic [5:0]  len_raw;
    logic [5:0]  len_cap;
    logic        far;
    logic [3:0]  flags_dec;
    logic [15:0] raw_len;
    logic [15:0] raw_clip;
    logic [15:0] raw_rem_dec;
    logic [23:0] produced_inc;
    logic        copy_end;
    logic        start_lit;
    logic        start_copy;
    phase_t      phase_d;
    logic [2:0]  end_status_d;

    function automatic logic [5:0] table_len(input logic [95:0] tbl, input logic [3:0] idx);
        logic [6:0] pos;
        pos = 7'(idx) * 7'd6;
        return tbl[pos +: 6];
    endfunction

    assign accept       = in_valid && (seq_reg == S_IDLE);
    assign in_stall     = (seq_reg != S_IDLE);
    assign b            = in_item.in_byte;
    assign last         = in_item.last_byte;
    assign room_ok      = produced_reg < cfg.out_limit;
    assign dist_w       = {held_reg[3:0], b};
    assign len_raw      = table_len({cfg.length_table_high, cfg.length_table_low},
                                    held_reg[7:4]);
    assign len_cap      = (len_raw > 6'(MAX_COPY)) ? 6'(MAX_COPY) : len_raw;
    assign far          = {12'd0, dist_w} > produced_reg;
    assign flags_dec    = (flags_left_reg == 4'd0) ? 4'd0 : flags_left_reg - 4'd1;
    assign raw_len      = {b, held_reg};
    assign raw_clip     = ({8'd0, raw_len} > cfg.out_limit) ? cfg.out_limit[15:0] : raw_len;
    assign raw_rem_dec  = (raw_rem_reg == 16'd0) ? 16'd0 : raw_rem_reg - 16'd1;
    assign produced_inc = produced_reg + 24'd1;
    assign copy_end     = (copy_cnt_reg == 6'd1) || (produced_inc == cfg.out_limit);

    always_comb
    begin
        phase_d         = phase_reg;
        end_status_d    = end_status_reg;
        flag_bits_next  = flag_bits_reg;
        flags_left_next = flags_left_reg;
        held_next       = held_reg;
        raw_rem_next    = raw_rem_reg;
        src_cnt_next    = src_cnt_reg;
        start_lit       = 1'b0;
        start_copy      = 1'b0;
        lit_next        = lit_reg;
        copy_cnt_next   = copy_cnt_reg;
        dist_next       = dist_reg;
        done_pend_next  = done_pend_reg;
        done_status_next = done_status_reg;
        done_short_next = done_short_reg;
        phase_next      = phase_reg;
        end_status_next = end_status_reg;

        if (accept)
        begin
            case (phase_reg)
                PH_METHOD:
                begin
                    if (b == cfg.compressed_method_code)
                    begin
                        phase_d = PH_FLAG;
                    end
                    else if (b == cfg.raw_method_code)
                    begin
                        phase_d = PH_RAW_SKIP;
                    end
                    else
                    begin
                        phase_d      = PH_STOP;
                        end_status_d = ST_METHOD;
                    end
                end
                PH_FLAG:
                begin
                    if (!last)
                    begin
                        flag_bits_next  = b;
                        flags_left_next = 4'd8;
                        phase_d         = PH_ITEM;
                    end
                end
                PH_ITEM:
                begin
                    if (!last)
                    begin
                        if (flag_bits_reg[0])
                        begin
                            held_next = b;
                            phase_d   = PH_CODE2;
                        end
                        else
                        begin
                            start_lit       = room_ok;
                            lit_next        = b;
                            flag_bits_next  = flag_bits_reg >> 1;
                            flags_left_next = flags_dec;
                            phase_d         = (flags_dec == 4'd0) ? PH_FLAG : PH_ITEM;
                        end
                    end
                end
                PH_CODE2:
                begin
                    if (dist_w == 12'd0)
                    begin
                        phase_d      = PH_STOP;
                        end_status_d = ST_END;
                    end
                    else if (far)
                    begin
                        phase_d      = PH_STOP;
                        end_status_d = ST_FAR;
                    end
                    else
                    begin
                        start_copy      = room_ok && (len_cap != 6'd0);
                        copy_cnt_next   = len_cap;
                        dist_next       = dist_w;
                        flag_bits_next  = flag_bits_reg >> 1;
                        flags_left_next = flags_dec;
                        phase_d         = (flags_dec == 4'd0) ? PH_FLAG : PH_ITEM;
                    end
                end
                PH_RAW_SKIP:
                begin
                    phase_d = PH_RAW_LO;
                end
                PH_RAW_LO:
                begin
                    held_next = b;
                    phase_d   = PH_RAW_HI;
                end
                PH_RAW_HI:
                begin
                    raw_rem_next = raw_clip;
                    if (raw_clip == 16'd0)
                    begin
                        phase_d      = PH_STOP;
                        end_status_d = ST_OK;
                    end
                    else
                    begin
                        phase_d = PH_RAW_DATA;
                    end
                end
                PH_RAW_DATA:
                begin
                    start_lit    = room_ok;
                    lit_next     = b;
                    raw_rem_next = raw_rem_dec;
                    if (raw_rem_dec == 16'd0)
                    begin
                        phase_d      = PH_STOP;
                        end_status_d = ST_OK;
                    end
                end
                PH_STOP:
                begin
                end
                default:
                begin
                end
            endcase

            src_cnt_next     = (src_cnt_reg < 3'd4) ? src_cnt_reg + 3'd1 : 3'd4;
            done_pend_next   = last;
            done_short_next  = src_cnt_reg < 3'd3;
            done_status_next = (src_cnt_reg < 3'd3) ? ST_SHORT :
                               (phase_d == PH_STOP) ? end_status_d : ST_OK;
            phase_next       = phase_d;
            end_status_next  = end_status_d;

            if (last)
            begin
                phase_next      = PH_METHOD;
                end_status_next = ST_OK;
                flag_bits_next  = 8'd0;
                flags_left_next = 4'd0;
                held_next       = 8'd0;
                raw_rem_next    = 16'd0;
                src_cnt_next    = 3'd0;
            end
        end
    end

    always_comb
    begin
        seq_next      = seq_reg;
        produced_next = produced_reg;
        emit          = 1'b0;
        res           = '0;
        hist_req      = '0;

        case (seq_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (start_lit)
                    begin
                        seq_next = S_LIT;
                    end
                    else if (start_copy)
                    begin
                        seq_next = S_RD;
                    end
                    else if (last)
                    begin
                        seq_next = S_DONE;
                    end
                end
            end
            S_LIT:
            begin
                if (out_free)
                begin
                    emit             = 1'b1;
                    res.out_byte     = lit_reg;
                    res.byte_valid   = 1'b1;
                    res.run_last     = !done_pend_reg;
                    hist_req.wr_en   = 1'b1;
                    hist_req.wr_addr = produced_reg[HIST_AW-1:0];
                    hist_req.wr_data = lit_reg;
                    produced_next    = produced_inc;
                    seq_next         = done_pend_reg ? S_DONE : S_IDLE;
                end
            end
            S_RD:
            begin
                hist_req.rd_en   = 1'b1;
                hist_req.rd_addr = produced_reg[HIST_AW-1:0] - dist_reg;
                seq_next         = S_WR;
            end
            S_WR:
            begin
                if (out_free)
                begin
                    emit             = 1'b1;
                    res.out_byte     = hist_data;
                    res.byte_valid   = 1'b1;
                    res.run_last     = copy_end && !done_pend_reg;
                    hist_req.wr_en   = 1'b1;
                    hist_req.wr_addr = produced_reg[HIST_AW-1:0];
                    hist_req.wr_data = hist_data;
                    produced_next    = produced_inc;
                    if (copy_end)
                    begin
                        seq_next = done_pend_reg ? S_DONE : S_IDLE;
                    end
                    else
                    begin
                        seq_next = S_RD;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    emit             = 1'b1;
                    res.done_res     = 1'b1;
                    res.total_length = done_short_reg ? 24'd0 : produced_reg;
                    res.status       = done_status_reg;
                    res.run_last     = 1'b1;
                    produced_next    = 24'd0;
                    seq_next         = S_IDLE;
                end
            end
            default:
            begin
                seq_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg         <= S_IDLE;
            phase_reg       <= PH_METHOD;
            flag_bits_reg   <= 8'd0;
            flags_left_reg  <= 4'd0;
            held_reg        <= 8'd0;
            raw_rem_reg     <= 16'd0;
            src_cnt_reg     <= 3'd0;
            end_status_reg  <= ST_OK;
            produced_reg    <= 24'd0;
            copy_cnt_reg    <= 6'd0;
            done_pend_reg   <= 1'b0;
            done_status_reg <= ST_OK;
            done_short_reg  <= 1'b0;
        end
        else
        begin
            seq_reg         <= seq_next;
            phase_reg       <= phase_next;
            flag_bits_reg   <= flag_bits_next;
            flags_left_reg  <= flags_left_next;
            held_reg        <= held_next;
            raw_rem_reg     <= raw_rem_next;
            src_cnt_reg     <= src_cnt_next;
            end_status_reg  <= end_status_next;
            produced_reg    <= produced_next;
            copy_cnt_reg    <= (seq_reg == S_WR && out_free) ? copy_cnt_reg - 6'd1
                                                             : copy_cnt_next;
            done_pend_reg   <= done_pend_next;
            done_status_reg <= done_status_next;
            done_short_reg  <= done_short_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lit_reg  <= lit_next;
        dist_reg <= dist_next;
    end

endmodule

// ===== bench/tb_lz77_block_decompressor.sv =====
// ----------------------------------------------------------------------------
// tb_lz77_block_decompressor
// Self-checking bench for the LZ77 block decompressor.
// ----------------------------------------------------------------------------
// Source blocks go through a queue-fed driver, and the results are compared
// field by field with a predictor that decodes each accepted byte. Directed
// blocks cover the method codes, raw mode, short and bad blocks, end markers,
// copies that reach too far, and codewords closed by the last byte. Random
// blocks follow under several register settings, including equal method codes
// and extreme output limits. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_lz77_block_decompressor;
    timeunit 1ns;
    timeprecision 1ps;

    import lzbd_pkg::*;

    localparam int unsigned WD_LIMIT = 3000;
    localparam int unsigned SETTLE   = 150;

    typedef enum logic [3:0] {
        DP_METHOD, DP_FLAG, DP_ITEM, DP_CODE2, DP_RAW_SKIP, DP_RAW_LO, DP_RAW_HI,
        DP_RAW_DATA, DP_END_OK, DP_END_MARK, DP_END_METHOD, DP_END_FAR
    } dec_phase_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_item;

    lz77_block_decompressor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    always #4 clk = ~clk;

    // register copies
    logic [7:0]  cfg_comp   = 8'h00;
    logic [7:0]  cfg_raw    = 8'h01;
    logic [23:0] cfg_limit  = 24'hFFFFFF;
    logic [47:0] cfg_len_lo = '0;
    logic [47:0] cfg_len_hi = '0;

    // decoder state
    logic [7:0]  hist_mem [0:WINDOW_SIZE-1];
    logic [23:0] n_out    = '0;
    logic [7:0]  flag_reg = '0;
    logic [3:0]  flag_cnt = '0;
    dec_phase_t  dphase   = DP_METHOD;
    logic [7:0]  code_hi  = '0;
    logic [15:0] raw_left = '0;
    logic [2:0]  src_seen = '0;

    out_item_t   decoded_q [$];
    out_item_t   held_res;
    logic        have_res = 1'b0;
    in_item_t    source_q [$];
    logic [7:0]  block_bytes [$];

    int          fails    = 0;
    int          n_sent   = 0;
    int          idle_cnt = 0;
    int          gap_cnt  = 0;
    int          stall_cnt = 0;
    logic        calm     = 1'b0;

    function automatic int unsigned len_at(input logic [3:0] idx);
        logic [95:0] t;
        t = {cfg_len_hi, cfg_len_lo};
        return 32'(t[6*idx +: 6]);
    endfunction

    function automatic void post_result(input logic [7:0] b, input logic v, input logic d,
                                        input logic [23:0] tot, input logic [2:0] st);
        out_item_t r;
        r.out_byte     = b;
        r.byte_valid   = v;
        r.done_res     = d;
        r.total_length = tot;
        r.status       = st;
        r.run_last     = 1'b0;
        if (have_res)
            decoded_q.push_back(held_res);
        held_res = r;
        have_res = 1'b1;
    endfunction

    function automatic void emit(input logic [7:0] b);
        if (n_out < cfg_limit)
        begin
            hist_mem[n_out[HIST_AW-1:0]] = b;
            n_out = n_out + 24'd1;
            post_result(b, 1'b1, 1'b0, 24'd0, ST_OK);
        end
    endfunction

    function automatic void advance_flag();
        flag_reg = flag_reg >> 1;
        if (flag_cnt > 0)
            flag_cnt = flag_cnt - 4'd1;
        if (flag_cnt == 0)
            dphase = DP_FLAG;
        else
            dphase = DP_ITEM;
    endfunction

    function automatic void apply_codeword(input logic [7:0] lo);
        logic [11:0] span;
        logic [23:0] src;
        int unsigned cnt;
        int unsigned room;
        span = {code_hi[3:0], lo};
        cnt  = len_at(code_hi[7:4]);
        if (span == 0)
            dphase = DP_END_MARK;
        else if (span > n_out)
            dphase = DP_END_FAR;
        else
        begin
            room = (cfg_limit > n_out) ? 32'(cfg_limit - n_out) : 0;
            if (cnt > room)
                cnt = room;
            for (int i = 0; i < cnt; i++)
            begin
                src = n_out - span;
                emit(hist_mem[src[HIST_AW-1:0]]);
            end
            advance_flag();
        end
    endfunction

    function automatic void decode_source_byte(input in_item_t it);
        logic [7:0]  b;
        logic [2:0]  prior;
        logic [2:0]  st;
        logic [23:0] tot;
        logic [31:0] rl;
        b = it.in_byte;
        prior = src_seen;
        case (dphase)
            DP_METHOD:
                if (b == cfg_comp)
                    dphase = DP_FLAG;
                else if (b == cfg_raw)
                    dphase = DP_RAW_SKIP;
                else
                    dphase = DP_END_METHOD;
            DP_FLAG:
                if (!it.last_byte)
                begin
                    flag_reg = b;
                    flag_cnt = 4'd8;
                    dphase = DP_ITEM;
                end
            DP_ITEM:
                if (!it.last_byte)
                begin
                    if (flag_reg[0])
                    begin
                        code_hi = b;
                        dphase = DP_CODE2;
                    end
                    else
                    begin
                        emit(b);
                        advance_flag();
                    end
                end
            DP_CODE2:
                apply_codeword(b);
            DP_RAW_SKIP:
                dphase = DP_RAW_LO;
            DP_RAW_LO:
            begin
                code_hi = b;
                dphase = DP_RAW_HI;
            end
            DP_RAW_HI:
            begin
                rl = {16'd0, b, code_hi};
                if (rl > {8'd0, cfg_limit})
                    rl = {8'd0, cfg_limit};
                raw_left = rl[15:0];
                if (raw_left == 0)
                    dphase = DP_END_OK;
                else
                    dphase = DP_RAW_DATA;
            end
            DP_RAW_DATA:
            begin
                emit(b);
                if (raw_left > 0)
                    raw_left = raw_left - 16'd1;
                if (raw_left == 0)
                    dphase = DP_END_OK;
            end
            default: ;
        endcase
        src_seen = (prior < 3'd4) ? prior + 3'd1 : 3'd4;
        if (it.last_byte)
        begin
            tot = n_out;
            st = ST_OK;
            if (prior < 3'd3)
            begin
                st = ST_SHORT;
                tot = '0;
            end
            else if (dphase == DP_END_MARK)
                st = ST_END;
            else if (dphase == DP_END_METHOD)
                st = ST_METHOD;
            else if (dphase == DP_END_FAR)
                st = ST_FAR;
            post_result(8'h00, 1'b0, 1'b1, tot, st);
            n_out = '0;
            flag_reg = '0;
            flag_cnt = '0;
            dphase = DP_METHOD;
            code_hi = '0;
            raw_left = '0;
            src_seen = '0;
        end
        if (have_res)
        begin
            held_res.run_last = 1'b1;
            decoded_q.push_back(held_res);
            have_res = 1'b0;
        end
    endfunction

    function automatic void check_result(input out_item_t got);
        out_item_t want;
        want = decoded_q.pop_front();
        if (got.out_byte !== want.out_byte)
        begin
            $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
            fails++;
        end
        if (got.byte_valid !== want.byte_valid)
        begin
            $error("byte_valid: expected %0b, actual %0b", want.byte_valid, got.byte_valid);
            fails++;
        end
        if (got.done_res !== want.done_res)
        begin
            $error("done_res: expected %0b, actual %0b", want.done_res, got.done_res);
            fails++;
        end
        if (got.total_length !== want.total_length)
        begin
            $error("total_length: expected %0d, actual %0d",
                   want.total_length, got.total_length);
            fails++;
        end
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            fails++;
        end
        if (got.run_last !== want.run_last)
        begin
            $error("run_last: expected %0b, actual %0b", want.run_last, got.run_last);
            fails++;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [47:0] rand_table(input int unsigned maxlen);
        logic [47:0] t;
        for (int i = 0; i < 8; i++)
            t[6*i +: 6] = 6'($urandom_range(0, maxlen));
        return t;
    endfunction

    function automatic logic [47:0] ramp_table(input int unsigned first);
        logic [47:0] t;
        for (int i = 0; i < 8; i++)
            t[6*i +: 6] = 6'(first + i);
        return t;
    endfunction

    always @(posedge clk)
        if ($urandom_range(0, 199) == 0)
            calm <= ~calm;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item <= '0;
            gap_cnt <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                decode_source_byte(in_item);
            if (!(in_valid && in_stall))
            begin
                if (gap_cnt > 0)
                begin
                    in_valid <= 1'b0;
                    gap_cnt <= gap_cnt - 1;
                end
                else if (source_q.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_item <= source_q.pop_front();
                    gap_cnt <= pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_cnt <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("unexpected result: out_byte %0h done_res %0b status %0d",
                           out_item.out_byte, out_item.done_res, out_item.status);
                    fails++;
                end
                else
                    check_result(out_item);
            end
            if (stall_cnt > 0)
            begin
                out_stall <= 1'b1;
                stall_cnt <= stall_cnt - 1;
            end
            else
            begin
                stall_cnt <= pick_gap();
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
    end

    initial
    begin
        while (idle_cnt < WD_LIMIT)
            @(posedge clk);
        $display("FAIL lz77_block_decompressor");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_COMPRESSED_CODE: cfg_comp = val[7:0];
            CFG_RAW_CODE:        cfg_raw = val[7:0];
            CFG_OUT_LIMIT:       cfg_limit = val[23:0];
            CFG_LEN_TABLE_LOW:   cfg_len_lo = val;
            CFG_LEN_TABLE_HIGH:  cfg_len_hi = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] comp, input logic [7:0] raw,
                              input logic [23:0] lim, input logic [47:0] lo,
                              input logic [47:0] hi);
        write_reg(CFG_COMPRESSED_CODE, {40'd0, comp});
        write_reg(CFG_RAW_CODE, {40'd0, raw});
        write_reg(CFG_OUT_LIMIT, {24'd0, lim});
        write_reg(CFG_LEN_TABLE_LOW, lo);
        write_reg(CFG_LEN_TABLE_HIGH, hi);
    endtask

    task automatic drain();
        while (source_q.size() != 0 || in_valid || decoded_q.size() != 0)
            @(posedge clk);
    endtask

    // mode 0: mark the final byte last, 1: append a last byte, 2: either
    task automatic send_block(input int mode);
        in_item_t it;
        if (mode == 2)
            mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
        if (mode == 1)
            block_bytes.push_back(8'($urandom));
        for (int i = 0; i < block_bytes.size(); i++)
        begin
            it.in_byte = block_bytes[i];
            it.last_byte = (i == block_bytes.size() - 1);
            source_q.push_back(it);
            n_sent++;
        end
        block_bytes.delete();
    endtask

    task automatic gen_compressed();
        int unsigned made;
        int unsigned ln;
        int unsigned reach;
        int          left;
        int          used;
        int          r;
        logic        stop;
        logic [7:0]  fl;
        logic [11:0] span;
        logic [3:0]  idx;
        logic [7:0]  first_b [0:7];
        logic [7:0]  second_b [0:7];
        made = 0;
        stop = 1'b0;
        left = $urandom_range(1, 16);
        block_bytes.push_back(cfg_comp);
        while (left > 0 && !stop)
        begin
            fl = 8'($urandom);
            used = 0;
            for (int j = 0; j < 8; j++)
            begin
                if (j < left && !stop)
                begin
                    if (made > 0)
                        fl[j] = ($urandom_range(0, 2) == 0);
                    else
                        fl[j] = ($urandom_range(0, 9) == 0);
                    if (!fl[j])
                    begin
                        first_b[j] = 8'($urandom);
                        if (made < cfg_limit)
                            made++;
                    end
                    else
                    begin
                        idx = 4'($urandom);
                        r = $urandom_range(0, 99);
                        if (r < 6)
                        begin
                            span = '0;
                            stop = 1'b1;
                        end
                        else if (r < 12 || made == 0)
                        begin
                            reach = made + 1 + $urandom_range(0, 20);
                            span = (reach > 4095) ? 12'hFFF : 12'(reach);
                            stop = 1'b1;
                        end
                        else
                        begin
                            span = 12'($urandom_range(1, (made > 4095) ? 4095 : made));
                            ln = len_at(idx);
                            if (made < cfg_limit)
                                made += (ln < cfg_limit - made) ? ln : cfg_limit - made;
                        end
                        first_b[j] = {idx, span[11:8]};
                        second_b[j] = span[7:0];
                    end
                    used = j + 1;
                end
            end
            block_bytes.push_back(fl);
            for (int j = 0; j < used; j++)
            begin
                block_bytes.push_back(first_b[j]);
                if (fl[j])
                    block_bytes.push_back(second_b[j]);
            end
            left -= used;
        end
        if (stop)
            repeat ($urandom_range(0, 3))
                block_bytes.push_back(8'($urandom));
        send_block(2);
    endtask

    task automatic gen_raw();
        int          r;
        int          cnt;
        logic [15:0] n;
        block_bytes.push_back(cfg_raw);
        block_bytes.push_back(8'($urandom));
        r = $urandom_range(0, 99);
        if (r < 10)
            n = '0;
        else if (r < 25)
            n = 16'($urandom);
        else
            n = 16'($urandom_range(1, 24));
        block_bytes.push_back(n[7:0]);
        block_bytes.push_back(n[15:8]);
        if (n > 24)
            cnt = $urandom_range(0, 24);
        else if (n == 0)
            cnt = $urandom_range(0, 2);
        else
            cnt = int'(n) - 1 + int'($urandom_range(0, 3));
        repeat (cnt)
            block_bytes.push_back(8'($urandom));
        send_block(2);
    endtask

    task automatic gen_block();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            gen_compressed();
        else if (r < 80)
            gen_raw();
        else if (r < 92)
        begin
            repeat ($urandom_range(1, 9))
                block_bytes.push_back(8'($urandom));
            send_block(2);
        end
        else
        begin
            block_bytes.push_back($urandom_range(0, 1) ? cfg_comp : 8'($urandom));
            repeat ($urandom_range(0, 2))
                block_bytes.push_back(8'($urandom));
            send_block(0);
        end
    endtask

    task automatic gen_random(input int count);
        int target;
        target = n_sent + count;
        while (n_sent < target)
            gen_block();
    endtask

    task automatic settle();
        drain();
        repeat (SETTLE)
            @(posedge clk);
    endtask

    initial
    begin
        logic [47:0] tab;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;

        tab = ramp_table(8);
        tab[47:42] = 6'd63;
        set_config(8'h00, 8'h01, 24'hFFFFFF, ramp_table(0), tab);

        block_bytes = '{8'h00};
        send_block(0);
        block_bytes = '{8'hFE, 8'h01, 8'h02, 8'h03};
        send_block(0);
        block_bytes = '{8'h01, 8'h00, 8'h01, 8'h00, 8'hAA};
        send_block(0);
        block_bytes = '{8'h00, 8'h0A, 8'hFF, 8'hF0, 8'h01, 8'h00, 8'h00, 8'h00, 8'h5A};
        send_block(0);
        block_bytes = '{8'h00, 8'h01, 8'h00, 8'h05, 8'h11};
        send_block(0);
        block_bytes = '{8'h00, 8'h02, 8'h41, 8'h20, 8'h01};
        send_block(0);
        settle();

        set_config(8'h5C, 8'hA3, 24'hFFFFFF, rand_table(6), rand_table(6));
        gen_random(35);
        drain();
        gen_random(35);
        settle();

        set_config(8'hFF, 8'hFF, 24'd40, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        gen_random(40);
        settle();

        set_config(8'hFF, 8'h00, 24'd0, 48'd0, 48'd0);
        gen_random(25);
        settle();

        set_config(8'h80, 8'h7F, 24'hFFFFFF, rand_table(10), rand_table(63));
        gen_random(50);
        settle();

        if (fails == 0)
            $display("PASS lz77_block_decompressor");
        else
            $display("FAIL lz77_block_decompressor");
        $finish;
    end

endmodule

// ===== lz77_block_decompressor.f =====
sv/lzbd_pkg.sv
sv/lzbd_hist.sv
sv/lzbd_core.sv
sv/lz77_block_decompressor.sv
bench/tb_lz77_block_decompressor.sv
